FILE: src/emdf_pkg.sv
// Shared types and constants for the echo median distance filter.
// No dependencies; imported by every module of the block.
package emdf_pkg;

  // Field widths
  localparam int DUR_W      = 16;
  localparam int SPEED_W    = 12;
  localparam int DIST_W     = 20;
  localparam int COUNT_W    = 3;
  localparam int PROD_W     = DUR_W + SPEED_W;
  localparam int PROD_SHIFT = 8;
  localparam int CFG_IDX_W  = 1;

  // Register reset values
  localparam logic [SPEED_W-1:0] HALF_SPEED_RESET = 12'd1124;
  localparam logic [DIST_W-1:0]  MIN_DIST_RESET   = 20'd1536;

  // Saturation value of the reported count
  localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SPEED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 1'b1;

  typedef logic [DIST_W-1:0] dist_t;

  // Command broadcast to every cell of the sorting chain
  typedef struct packed {
    logic  ins;
    logic  clr;
    dist_t value;
  } emdf_cmd_t;

endpackage

FILE: src/emdf_cell.sv
// One cell of the sorted insertion chain: holds one distance and its valid bit.
// Depends on emdf_pkg.
module emdf_cell import emdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  emdf_cmd_t cmd,
  input  logic      left_gt,
  input  logic      left_valid,
  input  dist_t     left_value,
  output logic      hold_gt,
  output logic      hold_valid,
  output dist_t     hold_value
);

  logic valid;
  dist_t value;
  logic take_left;
  logic take_new;

  // Flag a stored value that sorts after the incoming one
  assign hold_gt    = valid && (value > cmd.value);
  assign hold_valid = valid;
  assign hold_value = value;

  // Shift right when the left neighbor moves, or take the new value at its slot
  assign take_left = cmd.ins && left_gt;
  assign take_new  = cmd.ins && !left_gt && left_valid && (hold_gt || !valid);

  // Hold the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clr) begin
      valid <= 1'b0;
    end else if (take_left || take_new) begin
      valid <= 1'b1;
    end
  end

  // Hold the distance
  always_ff @(posedge clk) begin
    if (take_left) begin
      value <= left_value;
    end else if (take_new) begin
      value <= cmd.value;
    end
  end

endmodule

FILE: src/emdf_chain.sv
// Row of insertion cells that keeps kept distances in ascending order.
// Depends on emdf_pkg and emdf_cell.
module emdf_chain import emdf_pkg::*; #(
  parameter int WINDOW = 5,
  parameter int CNT_W  = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  emdf_cmd_t        cmd,
  input  logic [CNT_W-1:0] mid,
  output dist_t            median
);

  logic  gt_w  [WINDOW];
  logic  vld_w [WINDOW];
  dist_t val_w [WINDOW];

  genvar gi;
  generate
    for (gi = 0; gi < WINDOW; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        emdf_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cmd        (cmd),
          .left_gt    (1'b0),
          .left_valid (1'b1),
          .left_value ('0),
          .hold_gt    (gt_w[gi]),
          .hold_valid (vld_w[gi]),
          .hold_value (val_w[gi])
        );
      end else begin : g_body
        emdf_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .cmd        (cmd),
          .left_gt    (gt_w[gi-1]),
          .left_valid (vld_w[gi-1]),
          .left_value (val_w[gi-1]),
          .hold_gt    (gt_w[gi]),
          .hold_valid (vld_w[gi]),
          .hold_value (val_w[gi])
        );
      end
    end
  endgenerate

  // Pick the middle cell
  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (mid == CNT_W'(i)) begin
        median = val_w[i];
      end
    end
  end

endmodule

FILE: src/echo_median_distance_filter_unit.sv
// Echo median distance filter: scales echo durations to distances, keeps those with
// nonzero duration at or above the minimum in a sorted cell chain, reports the median
// once per window. Each sample is accepted, then takes a single insertion step in the
// chain; no new sample is accepted before that step. A window-closing sample then
// waits in the emit state while the last result stalls, then registers its result.
// Reset (rst, synchronous): registers return to defaults, the window and chain empty.
module echo_median_distance_filter_unit import emdf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DUR_W-1:0]     echo_duration_us,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DIST_W-1:0]    distance_q8,
  output logic                 found,
  output logic [COUNT_W-1:0]   kept_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int CNT_W = $clog2(WINDOW + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [SPEED_W-1:0] half_speed_q16;
  logic [DIST_W-1:0]  min_distance_q8;
  logic [CNT_W-1:0]   kept_total;
  logic [CNT_W-1:0]   window_position;
  dist_t              scaled;
  logic               dur_nz;
  logic [PROD_W-1:0]  prod_full;
  logic               in_acc;
  logic               emit_go;
  logic               keep;
  emdf_cmd_t          cmd;
  dist_t              median;
  logic [4:0]         total_ext;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Update configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      half_speed_q16  <= HALF_SPEED_RESET;
      min_distance_q8 <= MIN_DIST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HALF_SPEED: half_speed_q16  <= cfg_data[SPEED_W-1:0];
        REG_MIN_DIST:   min_distance_q8 <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Scale the accepted duration to a distance
  assign prod_full = PROD_W'(echo_duration_us) * PROD_W'(half_speed_q16);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      scaled <= prod_full[PROD_W-1:PROD_SHIFT];
      dur_nz <= (echo_duration_us != '0);
    end
  end

  // Decide whether the sample is kept, and when the result can leave
  assign keep    = (state == ST_INSERT) && dur_nz && (scaled >= min_distance_q8);
  assign emit_go = (state == ST_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    cmd.ins   = keep;
    cmd.clr   = emit_go;
    cmd.value = scaled;
  end

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_acc) state_next = ST_INSERT;
      ST_INSERT: begin
        if (window_position == CNT_W'(WINDOW - 1)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT:   if (emit_go) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count samples and kept distances in the window
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_total      <= '0;
      window_position <= '0;
    end else if (emit_go) begin
      kept_total      <= '0;
      window_position <= '0;
    end else if (state == ST_INSERT) begin
      window_position <= window_position + 1'b1;
      if (keep) begin
        kept_total <= kept_total + 1'b1;
      end
    end
  end

  emdf_chain #(
    .WINDOW (WINDOW),
    .CNT_W  (CNT_W)
  ) u_chain (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .mid    (kept_total >> 1),
    .median (median)
  );

  assign total_ext = 5'(kept_total);

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      found <= (kept_total != '0);
      distance_q8 <= (kept_total != '0) ? median : '0;
      kept_count  <= (total_ext > 5'(COUNT_MAX)) ? COUNT_MAX : total_ext[COUNT_W-1:0];
    end
  end

endmodule

FILE: src/emdf_checker.sv
// Port-level checks for the echo median distance filter, bound to the top level.
// Depends on emdf_pkg and echo_median_distance_filter_unit.
module emdf_checker import emdf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DIST_W-1:0]    distance_q8,
  input logic                 found,
  input logic [COUNT_W-1:0]   kept_count
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(distance_q8) && $stable(kept_count))
    else $error("stalled result changed");

  // An empty window reports zero distance and zero count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> distance_q8 == '0 && kept_count == '0)
    else $error("empty window with nonzero fields");

  // A found result has at least one kept sample, no more than the window
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> kept_count != '0 && 32'(kept_count) <= WINDOW)
    else $error("kept count out of range");

  // Each accepted sample occupies the block for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("sample accepted without insert cycle");

endmodule

bind echo_median_distance_filter_unit emdf_checker #(.WINDOW(WINDOW)) u_emdf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .distance_q8 (distance_q8),
  .found       (found),
  .kept_count  (kept_count)
);

FILE: dv/tb_echo_median_distance_filter_unit.sv
// Self-checking testbench for echo_median_distance_filter_unit: directed and random echo
// windows are predicted in-bench and each reported median is checked as it is accepted.
// Depends on emdf_pkg and the filter unit RTL only.
module tb_echo_median_distance_filter_unit;
  import emdf_pkg::*;

  localparam int WINDOW         = 5;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int LONG_HOLD      = 80;

  typedef struct packed {
    dist_t              distance;
    logic               found;
    logic [COUNT_W-1:0] count;
  } median_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [DUR_W-1:0]     echo_duration_us = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DIST_W-1:0]    distance_q8;
  logic                 found;
  logic [COUNT_W-1:0]   kept_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HALF_SPEED;
  logic [31:0]          cfg_data = '0;

  // Shadow of the block's registers and window state
  logic [SPEED_W-1:0]   speed_cfg = HALF_SPEED_RESET;
  dist_t                min_cfg = MIN_DIST_RESET;
  dist_t                kept_dist [WINDOW];
  int unsigned          kept_n = 0;
  int unsigned          window_pos = 0;
  median_result_t       pending_medians [$];

  int unsigned          fault_count = 0;
  int unsigned          quiet_cycles = 0;
  bit                   idle_on = 1'b1;
  bit                   hold_pending = 1'b0;
  int unsigned          hold_left = 0;
  int unsigned          burst_left = 0;

  echo_median_distance_filter_unit #(.WINDOW(WINDOW)) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .echo_duration_us (echo_duration_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .distance_q8      (distance_q8),
    .found            (found),
    .kept_count       (kept_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  // Scale one echo, keep it if reliable, and queue the median when the window closes
  task automatic absorb_echo(input logic [DUR_W-1:0] dur);
    logic [PROD_W-1:0] prod;
    dist_t             scaled_dist;
    dist_t             sorted [WINDOW];
    dist_t             v;
    int unsigned       j;
    median_result_t    res;
    if (dur != '0) begin
      prod = PROD_W'(dur) * PROD_W'(speed_cfg);
      scaled_dist = dist_t'(prod >> PROD_SHIFT);
      if (scaled_dist >= min_cfg && kept_n < WINDOW) begin
        kept_dist[kept_n] = scaled_dist;
        kept_n++;
      end
    end
    window_pos++;
    if (window_pos == WINDOW) begin
      res = '0;
      if (kept_n != 0) begin
        // insertion sort of the kept distances, median at index count/2
        sorted = kept_dist;
        for (int unsigned i = 1; i < kept_n; i++) begin
          v = sorted[i];
          j = i;
          while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = v;
        end
        res.distance = sorted[kept_n/2];
        res.found    = 1'b1;
        res.count    = (kept_n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(kept_n);
      end
      pending_medians.push_back(res);
      kept_n     = 0;
      window_pos = 0;
    end
  endtask

  // Compare one accepted result with the oldest queued median
  task automatic check_median();
    median_result_t got;
    median_result_t want;
    got = {distance_q8, found, kept_count};
    if (pending_medians.size() == 0) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("unexpected result: distance %0d found %0d count %0d",
                 got.distance, got.found, got.count);
    end else begin
      want = pending_medians.pop_front();
      if (got.distance !== want.distance || got.found !== want.found ||
          got.count !== want.count) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("median mismatch: exp distance %0d found %0d count %0d, got %0d %0d %0d",
                   want.distance, want.found, want.count,
                   got.distance, got.found, got.count);
      end
    end
  endtask

  // Track every transaction on the three channels, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HALF_SPEED: speed_cfg = cfg_data[SPEED_W-1:0];
          REG_MIN_DIST:   min_cfg   = cfg_data[DIST_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) check_median();
      if (in_valid && !in_stall) absorb_echo(echo_duration_us);
      if ((cfg_valid && cfg_ready) || (out_valid && !out_stall) || (in_valid && !in_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("echo_median_distance_filter_unit regression: fail");
        $finish;
      end
    end
  end

  // Drive result backpressure: one long hold on request, else random bursts
  always @(posedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      burst_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one echo and hold it until accepted; valid stays high for the next one
  task automatic send_echo(input logic [DUR_W-1:0] dur);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    echo_duration_us <= dur;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every queued median has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Issue one register write; valid is left high for the caller to drop
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write both registers with the block idle; unused upper data bits get noise
  task automatic reconfigure(input logic [SPEED_W-1:0] speed, input dist_t min_dist);
    drain_results();
    write_reg(REG_HALF_SPEED, ($urandom & ~32'hFFF) | 32'(speed));
    write_reg(REG_MIN_DIST, ($urandom & ~32'hFFFFF) | 32'(min_dist));
    cfg_valid <= 1'b0;
  endtask

  // Bias durations around the reliability threshold, zero and the range ends
  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned sel;
    int unsigned knee;
    sel = $urandom_range(0, 99);
    if (sel < 15) return '0;
    if (sel < 45 && speed_cfg != '0) begin
      knee = min_cfg;
      knee = (knee << PROD_SHIFT) / speed_cfg + $urandom_range(0, 4);
      knee = (knee >= 2) ? knee - 2 : 0;
      if (knee > 65535) knee = 65535 - $urandom_range(0, 3);
      return knee[DUR_W-1:0];
    end
    if (sel < 50) return DUR_W'($urandom_range(1, 16));
    if (sel < 55) return DUR_W'(65535 - $urandom_range(0, 15));
    return DUR_W'($urandom);
  endfunction

  // Reset settings: empty window, threshold edges, odd and even kept counts
  task automatic test_threshold_windows();
    logic [DUR_W-1:0] seq [20] = '{0, 0, 0, 0, 0,
                                    65535, 349, 350, 0, 1,
                                    40000, 30000, 20000, 10000, 500,
                                    700, 0, 2000, 351, 60000};
    foreach (seq[i]) send_echo(seq[i]);
  endtask

  // Fastest speed, no minimum: largest distance, tiny distance, zero never kept
  task automatic test_register_extremes();
    logic [DUR_W-1:0] seq [5] = '{65535, 1, 0, 32768, 65535};
    reconfigure(12'd4095, '0);
    foreach (seq[i]) send_echo(seq[i]);
  endtask

  // Random echoes over several register settings, phases not aligned to windows
  task automatic test_random_phases();
    logic [SPEED_W-1:0] speed;
    dist_t              min_dist;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin speed = 12'd0;    min_dist = '0;          end
        1: begin speed = 12'd4095; min_dist = 20'hFFFFF;   end
        2: begin speed = 12'd4095; min_dist = '0;          end
        3: begin speed = HALF_SPEED_RESET; min_dist = MIN_DIST_RESET; end
        default: begin
          speed    = SPEED_W'($urandom);
          min_dist = dist_t'($urandom_range(0, 262143));
        end
      endcase
      reconfigure(speed, min_dist);
      idle_on = (p != 5);
      repeat ($urandom_range(90, 110)) send_echo(pick_duration());
    end
    idle_on = 1'b1;
  endtask

  // Hold off the result side for a long stretch while echoes keep coming
  task automatic test_backpressure_fill();
    reconfigure(HALF_SPEED_RESET, MIN_DIST_RESET);
    hold_pending = 1'b1;
    repeat (30) send_echo(pick_duration());
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_full_rate();
    drain_results();
    idle_on = 1'b0;
    repeat (60) send_echo(pick_duration());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_threshold_windows();
    test_register_extremes();
    test_random_phases();
    test_backpressure_fill();
    test_full_rate();
    drain_results();
    if (fault_count == 0)
      $display("echo_median_distance_filter_unit regression: pass");
    else
      $display("echo_median_distance_filter_unit regression: fail");
    $finish;
  end

endmodule

FILE: files.f
src/emdf_pkg.sv
src/emdf_cell.sv
src/emdf_chain.sv
src/echo_median_distance_filter_unit.sv
src/emdf_checker.sv
dv/tb_echo_median_distance_filter_unit.sv
